/* rtl/lkvc_pkg.sv */
// Shared types, sizes and codes for the LRU key-value cache.
// Depends on nothing; every module of the cache imports this package.
package lkvc_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int CAP_BITS    = 5;

   localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_BITS   = IDX_BITS;
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_BITS    = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      logic                  req_type;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
   } rsp_item_type;

   typedef struct packed {
      op_type                op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } work_item_type;

   typedef struct packed {
      logic push;
   } push_ctrl_type;

endpackage

/* rtl/lru_key_value_cache.sv */
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg, lkvc_front, lkvc_queue and lkvc_engine.
//
//   Channel   Ports                              Direction  Beat content
//   request   req_valid, req_ready, req_item     in         get/put, key, value
//   response  rsp_valid, rsp_ready, rsp_item     out        hit flag, read value
//   config    csr_write_enable, csr_write_data   in         capacity in use
//
// A request beat enters a decode stage, moves into a two-entry work queue and
// is executed by the engine, which registers its response; a full queue or an
// untaken response can hold the beat at either of these hand-overs. The
// engine executes one request per cycle while the response side does not
// stall, so the sustained rate is one beat per cycle, set by the combinational
// match-and-update of the entry array. Reset is synchronous and empties the
// store. Either side may stall independently: the queue absorbs requests
// while the response register holds an untaken beat.
module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_item_type        req_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_item_type        rsp_item,
   input  logic                csr_write_enable,
   input  logic [CAP_BITS-1:0] csr_write_data
);

   // The capacity register resets to the full store size.
   logic [CAP_BITS-1:0] capacity_ff, capacity_in;

   push_ctrl_type push_ctrl;
   work_item_type push_item;
   work_item_type work_item;
   logic          queue_ready;
   logic          work_valid;
   logic          work_pop;

   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_BITS'(MAX_ENTRIES);
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Decode stage: holds one beat and offers it to the queue.
   lkvc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .push_ctrl   (push_ctrl),
      .queue_ready (queue_ready),
      .push_item   (push_item)
   );

   // Work queue decouples the front end from the engine.
   lkvc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_ctrl  (push_ctrl),
      .push_item  (push_item),
      .push_ready (queue_ready),
      .pop_valid  (work_valid),
      .pop        (work_pop),
      .pop_item   (work_item)
   );

   // Engine pops a queued request only when the response register is free
   // or being drained in the same cycle.
   lkvc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .work_valid (work_valid),
      .work_item  (work_item),
      .work_pop   (work_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

/* rtl/lkvc_front.sv */
// Front end of the cache: takes request beats, decodes the operation and
// hands the decoded item to the work queue. Depends on lkvc_pkg.
module lkvc_front
   import lkvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_item_type  req_item,
   output push_ctrl_type push_ctrl,
   input  logic          queue_ready,
   output work_item_type push_item
);

   logic          stage_valid_ff, stage_valid_in;
   work_item_type stage_item_ff, stage_item_in;
   op_type        decoded_op;
   logic          accept;
   logic          push;

   always_comb begin
      case (req_item.req_type)
         1'b1:    decoded_op = OP_PUT;
         1'b0:    decoded_op = OP_GET;
         default: decoded_op = OP_GET;
      endcase
   end

   assign push      = stage_valid_ff && queue_ready;
   assign req_ready = !stage_valid_ff || queue_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
      stage_item_in       = stage_item_ff;
      if (accept) begin
         stage_item_in.op    = decoded_op;
         stage_item_in.key   = req_item.key;
         stage_item_in.value = req_item.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
   end

   assign push_ctrl.push  = push;
   assign push_item       = stage_item_ff;

endmodule

/* rtl/lkvc_queue.sv */
// Short work queue between the front end and the cache engine.
// Depends on lkvc_pkg for the item type and the queue depth.
module lkvc_queue
   import lkvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  push_ctrl_type push_ctrl,
   input  work_item_type push_item,
   output logic          push_ready,
   output logic          pop_valid,
   input  logic          pop,
   output work_item_type pop_item
);

   work_item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]     count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_ctrl.push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/lkvc_engine.sv */
// Cache engine: entry storage, parallel key match, recency ranks, eviction
// and the response register. Depends on lkvc_pkg.
module lkvc_engine
   import lkvc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CAP_BITS-1:0] capacity,
   input  logic                work_valid,
   input  work_item_type       work_item,
   output logic                work_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_item_type        rsp_item
);

   logic [KEY_BITS-1:0]   key_ff   [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [MAX_ENTRIES];
   logic [RANK_BITS-1:0]  rank_ff  [MAX_ENTRIES];
   logic [RANK_BITS-1:0]  rank_in  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_BITS-1:0]   occ_ff, occ_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   logic [MAX_ENTRIES-1:0] match;
   logic [MAX_ENTRIES-1:0] victim;
   logic [MAX_ENTRIES-1:0] valid_kept;
   logic                  hit;
   logic [IDX_BITS-1:0]   hit_idx;
   logic [RANK_BITS-1:0]  hit_rank;
   logic [IDX_BITS-1:0]   free_idx;
   logic                  free_found;
   logic [CMP_BITS-1:0]   cap_wide, eff_cap;
   logic [CNT_BITS-1:0]   occ_minus_one;
   logic                  need_evict, do_evict, do_insert, write_entry;
   logic [IDX_BITS-1:0]   write_idx;

   assign work_pop = work_valid && (!rsp_valid_ff || rsp_ready);

   // Parallel key compare; the lowest matching slot wins.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (key_ff[i] == work_item.key);
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = IDX_BITS'(i);
         end
      end
   end

   assign hit_rank = rank_ff[hit_idx];

   // Capacity of zero behaves as one; anything above the store size is clamped.
   always_comb begin
      cap_wide = CMP_BITS'(capacity);
      if (cap_wide == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (cap_wide > CMP_BITS'(MAX_ENTRIES)) begin
         eff_cap = CMP_BITS'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_wide;
      end
   end

   assign need_evict    = CMP_BITS'(occ_ff) >= eff_cap;
   assign occ_minus_one = occ_ff - 1'b1;
   assign do_insert     = (work_item.op == OP_PUT) && !hit;
   assign do_evict      = do_insert && need_evict && (occ_ff != '0);

   // Valid ranks are a permutation of 0..occ-1, so the oldest has rank occ-1.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         victim[i] = valid_ff[i] && (rank_ff[i] == occ_minus_one[RANK_BITS-1:0]);
      end
      valid_kept = do_evict ? (valid_ff & ~victim) : valid_ff;
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_kept[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      write_entry  = 1'b0;
      write_idx    = hit_idx;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (work_pop) begin
         rsp_valid_in           = 1'b1;
         rsp_item_in.hit        = hit;
         rsp_item_in.read_value = '0;
         if (hit) begin
            // Touch: entries more recent than the hit slot age by one.
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[hit_idx] = '0;
            if (work_item.op == OP_PUT) begin
               write_entry = 1'b1;
            end else begin
               rsp_item_in.read_value = value_ff[hit_idx];
            end
         end else if (do_insert) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_kept[i]) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end else if (do_evict && victim[i]) begin
                  rank_in[i] = '0;
               end
            end
            valid_in = valid_kept;
            occ_in   = do_evict ? occ_minus_one : occ_ff;
            if (free_found) begin
               valid_in[free_idx] = 1'b1;
               rank_in[free_idx]  = '0;
               occ_in             = occ_in + 1'b1;
               write_entry        = 1'b1;
               write_idx          = free_idx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (write_entry) begin
         key_ff[write_idx]   <= work_item.key;
         value_ff[write_idx] <= work_item.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* verif/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key-value cache (lru_key_value_cache).
// Depends on lkvc_pkg for the beat types and the get/put codes; needs only the RTL.
module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   // Settling wait of the drain, after every owed response is back.
   localparam int DRAIN_CYCLES     = 8;
   localparam int END_WAIT_CYCLES  = 4000;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PHASE_BEATS      = 200;
   localparam int NUM_PHASES       = 10;
   localparam int KEY_POOL_SIZE    = 32;
   localparam int IDLE_PERCENT     = 12;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_item_type        req_item;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_item_type        rsp_item;
   logic                csr_write_enable;
   logic [CAP_BITS-1:0] csr_write_data;

   lru_key_value_cache u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the cache. Each line holds a valid flag, key, value
   // and a recency rank where 0 is the most recently used line.
   // ------------------------------------------------------------------
   logic [CAP_BITS-1:0]   shadow_capacity;
   bit                    line_valid [MAX_ENTRIES];
   logic [KEY_BITS-1:0]   line_key   [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] line_value [MAX_ENTRIES];
   int                    line_rank  [MAX_ENTRIES];
   int                    lines_used;

   // Tallies for the closing summary.
   int get_hits, get_misses, put_updates, inserts, evictions, capacity_writes;

   // Responses still owed by the cache, oldest first.
   rsp_item_type pending_rsp_q[$];
   int           error_count;
   int           beats_checked;

   // Handshake between the stimulus and the response side.
   bit no_idle;
   bit long_hold_pending;

   function automatic void clear_shadow();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         line_valid[i] = 1'b0;
         line_key[i]   = '0;
         line_value[i] = '0;
         line_rank[i]  = 0;
      end
      lines_used      = 0;
      shadow_capacity = CAP_BITS'(16);
   endfunction

   // Apply one request to the shadow cache and return the response it owes.
   function automatic rsp_item_type predict_access(input req_item_type beat);
      rsp_item_type answer;
      int           slot;
      int           oldest;
      int           limit;
      int           old_rank;
      answer = '0;
      slot   = -1;
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (slot < 0 && line_valid[i] && line_key[i] == beat.key)
            slot = i;

      if (slot >= 0) begin
         // A hit on either operation promotes the line to most recent. A get
         // returns the stored value; a put overwrites it and returns zero.
         answer.hit = 1'b1;
         if (beat.req_type == OP_PUT) begin
            line_value[slot] = beat.value;
            put_updates++;
         end else begin
            answer.read_value = line_value[slot];
            get_hits++;
         end
         old_rank = line_rank[slot];
         for (int i = 0; i < MAX_ENTRIES; i++)
            if (line_valid[i] && line_rank[i] < old_rank)
               line_rank[i]++;
         line_rank[slot] = 0;
         return answer;
      end

      if (beat.req_type == OP_GET) begin
         get_misses++;
         return answer;
      end

      // A zero capacity behaves as one, anything above the array size as
      // the full array. Only one line is dropped per insert, so lowering the
      // capacity shrinks occupancy gradually.
      limit = (shadow_capacity == 0) ? 1 :
              (shadow_capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_capacity);
      if (lines_used >= limit) begin
         oldest = -1;
         for (int i = 0; i < MAX_ENTRIES; i++)
            if (line_valid[i] && (oldest < 0 || line_rank[i] > line_rank[oldest]))
               oldest = i;
         if (oldest >= 0) begin
            line_valid[oldest] = 1'b0;
            line_rank[oldest]  = 0;
            lines_used--;
            evictions++;
         end
      end

      slot = -1;
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (slot < 0 && !line_valid[i])
            slot = i;
      if (slot >= 0) begin
         for (int i = 0; i < MAX_ENTRIES; i++)
            if (line_valid[i])
               line_rank[i]++;
         line_valid[slot] = 1'b1;
         line_key[slot]   = beat.key;
         line_value[slot] = beat.value;
         line_rank[slot]  = 0;
         lines_used++;
         inserts++;
      end
      return answer;
   endfunction

   // ------------------------------------------------------------------
   // Response side. The ready line stalls at random except during the
   // no-idle stretch, and once holds off for a long count of cycles so
   // that the work queue fills and the request side backs up.
   // ------------------------------------------------------------------
   initial begin : response_driver
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (int n = 0; n < LONG_HOLD_CYCLES; n++)
               @(posedge clock);
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Every response beat is checked against the oldest owed response.
   always @(posedge clock) begin
      rsp_item_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: response beat with none owed, actual hit %0b value %h",
                     $time, rsp_item.hit, rsp_item.read_value);
            error_count++;
         end else begin
            wanted = pending_rsp_q.pop_front();
            beats_checked++;
            if (rsp_item.hit !== wanted.hit) begin
               $display("%0t: hit mismatch, expected %0b, actual %0b",
                        $time, wanted.hit, rsp_item.hit);
               error_count++;
            end
            if (rsp_item.read_value !== wanted.read_value) begin
               $display("%0t: read_value mismatch, expected %h, actual %h",
                        $time, wanted.read_value, rsp_item.read_value);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------

   // Offer one request beat and hold it until it is taken. A row with a
   // hand-written answer still runs through the shadow cache to keep its
   // state in step, but the written answer is what gets checked.
   task automatic send_request(input req_item_type beat, input bit fixed_answer,
                               input rsp_item_type written_answer);
      bit           gap_open;
      rsp_item_type predicted;
      gap_open = 1'b0;
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         if (!gap_open)
            req_valid <= 1'b0;
         gap_open = 1'b1;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= beat;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = predict_access(beat);
      pending_rsp_q.push_back(fixed_answer ? written_answer : predicted);
   endtask

   // Drop valid and let the cache run dry: every owed response back, then
   // a settling wait of DRAIN_CYCLES for the pipeline.
   task automatic drain_cache();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called while the cache is idle.
   task automatic write_capacity(input logic [CAP_BITS-1:0] setting);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity = setting;
      capacity_writes++;
   endtask

   // Directed rows, run at the reset capacity of sixteen.
   typedef struct {
      req_item_type beat;
      bit           fixed_answer;
      rsp_item_type answer;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic void add_row(input op_type op, input logic [KEY_BITS-1:0] key,
                                   input logic [VALUE_BITS-1:0] value,
                                   input bit fixed_answer, input logic hit,
                                   input logic [VALUE_BITS-1:0] read_value);
      directed_row_type row;
      row.beat.req_type     = op;
      row.beat.key          = key;
      row.beat.value        = value;
      row.fixed_answer      = fixed_answer;
      row.answer.hit        = hit;
      row.answer.read_value = read_value;
      directed_rows.push_back(row);
   endfunction

   function automatic void build_directed_rows();
      // Empty cache: gets at both key extremes miss.
      add_row(OP_GET, '0, '1, 1'b1, 1'b0, '0);
      add_row(OP_GET, '1, '0, 1'b1, 1'b0, '0);
      // New keys go in with no hit and a zero value.
      add_row(OP_PUT, '0, '1, 1'b1, 1'b0, '0);
      add_row(OP_PUT, '1, '0, 1'b1, 1'b0, '0);
      // Get hits return what was stored, at both value extremes.
      add_row(OP_GET, '0, '0, 1'b1, 1'b1, '1);
      add_row(OP_GET, '1, '1, 1'b1, 1'b1, '0);
      // A put to a held key reports a hit with zero value, then reads back.
      add_row(OP_PUT, '0, 32'hA5A5_5A5A, 1'b1, 1'b1, '0);
      add_row(OP_GET, '0, '0, 1'b1, 1'b1, 32'hA5A5_5A5A);
      add_row(OP_GET, 32'h1234_5678, '0, 1'b1, 1'b0, '0);
      // Fill past sixteen lines; the all-ones key is least recent and goes.
      for (int k = 1; k <= 15; k++)
         add_row(OP_PUT, KEY_BITS'(k), VALUE_BITS'(32'h100 * k), 1'b0, 1'b0, '0);
      add_row(OP_GET, '1, '0, 1'b0, 1'b0, '0);
      add_row(OP_GET, '0, '0, 1'b0, 1'b0, '0);
   endfunction

   // Keys drawn by the random part. A narrow window of the pool per phase,
   // a little wider than the effective capacity, keeps hits and evictions
   // frequent; the pool holds both key extremes.
   logic [KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];

   function automatic req_item_type random_request(input int pool_base, input int pool_span);
      req_item_type beat;
      int           pick;
      beat.req_type = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
      if ($urandom_range(99) < 10) begin
         beat.key = $urandom;
      end else begin
         pick     = (pool_base + $urandom_range(pool_span - 1)) % KEY_POOL_SIZE;
         beat.key = key_pool[pick];
      end
      pick = $urandom_range(19);
      if (pick == 0)
         beat.value = '0;
      else if (pick == 1)
         beat.value = '1;
      else
         beat.value = $urandom;
      return beat;
   endfunction

   // Capacity per random phase: zero, one, the top of the field, a drop to
   // three right after the cache has filled, the array size, and a mix.
   logic [CAP_BITS-1:0] phase_capacity [NUM_PHASES];

   initial begin : stimulus
      rsp_item_type   no_answer;
      req_item_type   beat;
      logic [CAP_BITS-1:0] setting;
      int             effective;
      int             pool_base;
      int             pool_span;
      int             wait_cycles;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_item         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      no_idle           = 1'b0;
      long_hold_pending = 1'b0;
      error_count       = 0;
      beats_checked     = 0;
      no_answer         = '0;
      clear_shadow();

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_SIZE; i++)
         key_pool[i] = $urandom;
      phase_capacity = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd2, 5'd8, 5'd5, 5'd17, 5'd16};
      phase_capacity[8] = CAP_BITS'($urandom_range(31));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset capacity.
      build_directed_rows();
      foreach (directed_rows[r])
         send_request(directed_rows[r].beat, directed_rows[r].fixed_answer,
                      directed_rows[r].answer);
      drain_cache();

      for (int p = 0; p < NUM_PHASES; p++) begin
         setting = phase_capacity[p];
         write_capacity(setting);
         effective = (setting == 0) ? 1 : (setting > MAX_ENTRIES) ? MAX_ENTRIES : setting;
         pool_span = effective + $urandom_range(6);
         pool_base = $urandom_range(KEY_POOL_SIZE - 1);

         // The phase after the cache has filled at full size gets the long
         // receiver hold; a later one runs without any idling at all.
         if (p == 3)
            long_hold_pending = 1'b1;
         no_idle = (p == 6);

         for (int n = 0; n < PHASE_BEATS; n++) begin
            // Once, the sender pauses mid-phase until everything is back.
            if (p == 5 && n == PHASE_BEATS / 2)
               drain_cache();
            beat = random_request(pool_base, pool_span);
            send_request(beat, 1'b0, no_answer);
         end
         drain_cache();
      end
      no_idle = 1'b0;

      // Bounded wait for stragglers; anything still owed is a failure.
      wait_cycles = 0;
      while (pending_rsp_q.size() != 0 && wait_cycles < END_WAIT_CYCLES) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_rsp_q.size());
         error_count += pending_rsp_q.size();
      end

      $display("Checked %0d response beats: %0d get hits, %0d get misses, %0d put updates,",
               beats_checked, get_hits, get_misses, put_updates);
      $display("%0d inserts and %0d evictions across %0d capacity writes; %0d errors.",
               inserts, evictions, capacity_writes, error_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
